FILE: hw/rtl/rcfp_pkg.sv
`default_nettype none

package rcfp_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 10;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int IN_TDATA_W  = 72;

    // Fixed frame content
    localparam logic [7:0] HDR_BYTE0 = 8'hFF;
    localparam logic [7:0] HDR_BYTE1 = 8'hC3;
    localparam logic [7:0] CSUM_INV  = 8'hFF;

    // Flag byte bits
    localparam logic [7:0] FLAG_DRIBBLE = 8'h80;
    localparam logic [7:0] FLAG_FIXED   = 8'h20 | 8'h04 | 8'h02;
    localparam logic [7:0] FLAG_KICK    = 8'h10;
    localparam logic [7:0] FLAG_CHIP    = 8'h08;

    // Byte positions inside the frame
    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_HDR1  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_CSUM  = IDX_W'(8);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_BYTES - 1);

    // Speed and turn scaling
    localparam logic [8:0]  SPEED_CAP   = 9'd255;
    localparam logic [25:0] TURN_SCALE  = 26'd42722830;
    localparam logic signed [11:0] TURN_BIAS = 12'sd127;
    localparam logic signed [11:0] TURN_MAX  = 12'sd254;

    // Clamp a signed power request to 0..15
    function automatic logic [3:0] clamp_power(input logic signed [7:0] p);
        logic [3:0] r;
        if (p[7])
            r = 4'd0;
        else if (p > 8'sd15)
            r = 4'd15;
        else
            r = p[3:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/robot_command_frame_packer_unit.sv
// Robot command frame packer.
// Input stream (s_axis_*): one motion command per transfer, all fields in
// s_axis_tdata. Output stream (m_axis_*): the ten-byte radio frame for that
// command, one byte per transfer, byte 0 first, m_axis_tlast on byte 9.
// Frame: FF, C3, id, speed, heading, turn rate, flags, powers, XOR checksum
// of bytes 2..7, and the inverted checksum.
// A command accepted is latched into the input register, its frame is built
// into the frame register once that register is free, and byte 0 is
// offered from the cycle after that.
// Command throughput is set by the byte-wide output channel draining the
// frame register when the receiver never stalls. The next
// command is taken into the input register while the current frame drains,
// and its frame is loaded in the same cycle that byte 9 leaves.
// Reset clears both valid flags and the byte counter; no frame is offered.
// A receiver stall holds the current byte and, once the input register is
// full, drops s_axis_tready until the frame register frees up.
`default_nettype none

module robot_command_frame_packer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [3:0] robot_id, [19:4] speed, [35:20] heading, [51:36] turn_rate,
    // [59:52] dribble_level, [67:60] kick_level, [68] chip_kick, [71:69] zero
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] frame_byte
    output logic [7:0]       m_axis_tdata,
    // frame_end
    output logic             m_axis_tlast
);

    localparam int IDX_W = rcfp_pkg::IDX_W;

    // Input register
    logic        cmd_valid_reg;
    logic [71:0] cmd_reg;

    // Frame register and byte counter
    logic             frame_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       frame_reg [rcfp_pkg::FRAME_BYTES];
    logic [7:0]       frame_next [rcfp_pkg::FRAME_BYTES];

    logic out_xfer;
    logic last_xfer;
    logic frame_free;
    logic load_frame;

    // Unpacked command fields
    logic [3:0]         robot_id;
    logic signed [15:0] speed;
    logic [15:0]        heading;
    logic signed [15:0] turn_rate;
    logic signed [7:0]  dribble_level;
    logic signed [7:0]  kick_level;
    logic               chip_kick;

    // Datapath intermediates
    logic [22:0]        speed_scaled;
    logic [8:0]         speed_q;
    logic [7:0]         speed_byte;
    logic [24:0]        heading_prod;
    logic [24:0]        heading_round;
    logic [7:0]         heading_byte;
    logic               turn_neg;
    logic [15:0]        turn_mag;
    logic [41:0]        turn_prod;
    logic [41:0]        turn_round;
    logic [9:0]         turn_q;
    logic signed [11:0] turn_sum;
    logic [7:0]         turn_byte;
    logic [3:0]         dribble_pow;
    logic [3:0]         kick_pow;
    logic [7:0]         flag_byte;
    logic [7:0]         csum;

    // Handshake control
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign last_xfer     = out_xfer && (idx_reg == rcfp_pkg::IDX_LAST);
    assign frame_free    = !frame_valid_reg || last_xfer;
    assign load_frame    = cmd_valid_reg && frame_free;
    assign s_axis_tready = !cmd_valid_reg || frame_free;

    // Field extraction
    assign robot_id      = cmd_reg[3:0];
    assign speed         = cmd_reg[19:4];
    assign heading       = cmd_reg[35:20];
    assign turn_rate     = cmd_reg[51:36];
    assign dribble_level = cmd_reg[59:52];
    assign kick_level    = cmd_reg[67:60];
    assign chip_kick     = cmd_reg[68];

    // Speed: speed*255 >> 14, zero when negative, cap at 255
    always_comb
    begin
        speed_scaled = {speed[14:0], 8'd0} - 23'(speed[14:0]);
        speed_q      = speed_scaled[22:14];
        if (speed[15])
            speed_byte = 8'd0;
        else if (speed_q > rcfp_pkg::SPEED_CAP)
            speed_byte = 8'hFF;
        else
            speed_byte = speed_q[7:0];
    end

    // Heading: degrees rounded half up, then halved
    always_comb
    begin
        heading_prod  = {1'b0, heading, 8'd0} + {3'd0, heading, 6'd0}
                      + {4'd0, heading, 5'd0} + {6'd0, heading, 3'd0};
        heading_round = heading_prod + 25'd32768;
        heading_byte  = heading_round[24:17];
    end

    // Turn rate: scaled magnitude rounded away from zero, biased and clamped
    always_comb
    begin
        turn_neg   = turn_rate[15];
        turn_mag   = turn_neg ? 16'(-turn_rate) : 16'(turn_rate);
        turn_prod  = 42'(turn_mag) * 42'(rcfp_pkg::TURN_SCALE);
        turn_round = turn_prod + (42'd1 << 31);
        turn_q     = turn_round[41:32];
        if (turn_neg)
            turn_sum = rcfp_pkg::TURN_BIAS - signed'({2'd0, turn_q});
        else
            turn_sum = rcfp_pkg::TURN_BIAS + signed'({2'd0, turn_q});
        if (turn_sum < 12'sd0)
            turn_byte = 8'd0;
        else if (turn_sum > rcfp_pkg::TURN_MAX)
            turn_byte = 8'(rcfp_pkg::TURN_MAX);
        else
            turn_byte = turn_sum[7:0];
    end

    // Powers and flags
    always_comb
    begin
        dribble_pow = rcfp_pkg::clamp_power(dribble_level);
        kick_pow    = rcfp_pkg::clamp_power(kick_level);
        flag_byte   = rcfp_pkg::FLAG_FIXED;
        if (dribble_pow != 4'd0)
            flag_byte = flag_byte | rcfp_pkg::FLAG_DRIBBLE;
        if (kick_pow != 4'd0)
            flag_byte = flag_byte | rcfp_pkg::FLAG_KICK;
        if (chip_kick)
            flag_byte = flag_byte | rcfp_pkg::FLAG_CHIP;
    end

    // Assemble the frame
    always_comb
    begin
        csum = {4'd0, robot_id} ^ speed_byte ^ heading_byte ^ turn_byte ^ flag_byte
             ^ {dribble_pow, kick_pow};
        frame_next[0] = rcfp_pkg::HDR_BYTE0;
        frame_next[1] = rcfp_pkg::HDR_BYTE1;
        frame_next[2] = {4'd0, robot_id};
        frame_next[3] = speed_byte;
        frame_next[4] = heading_byte;
        frame_next[5] = turn_byte;
        frame_next[6] = flag_byte;
        frame_next[7] = {dribble_pow, kick_pow};
        frame_next[8] = csum;
        frame_next[9] = csum ^ rcfp_pkg::CSUM_INV;
    end

    // Input register: capture on transfer, release when the frame loads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            cmd_valid_reg <= 1'b1;
        else if (load_frame)
            cmd_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            cmd_reg <= s_axis_tdata;
    end

    // Frame control: advance per byte transfer, reload after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
            idx_reg         <= rcfp_pkg::IDX_FIRST;
        end
        else
        begin
            if (load_frame)
            begin
                frame_valid_reg <= 1'b1;
                idx_reg         <= rcfp_pkg::IDX_FIRST;
            end
            else if (last_xfer)
            begin
                frame_valid_reg <= 1'b0;
                idx_reg         <= rcfp_pkg::IDX_FIRST;
            end
            else if (out_xfer)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_frame)
            frame_reg <= frame_next;
    end

    // Output side
    assign m_axis_tvalid = frame_valid_reg;
    assign m_axis_tdata  = frame_reg[idx_reg];
    assign m_axis_tlast  = (idx_reg == rcfp_pkg::IDX_LAST);

endmodule

`default_nettype wire

FILE: hw/rtl/rcfp_checker.sv
`default_nettype none

module rcfp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast
);

    localparam int IDX_W = rcfp_pkg::IDX_W;

    logic             out_xfer;
    logic [IDX_W-1:0] pos_reg;
    logic [7:0]       xor_reg;
    logic [7:0]       prev_reg;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Track the position within the frame and the running checksum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= rcfp_pkg::IDX_FIRST;
            xor_reg  <= 8'd0;
            prev_reg <= 8'd0;
        end
        else if (out_xfer)
        begin
            prev_reg <= m_axis_tdata;
            if (pos_reg == rcfp_pkg::IDX_LAST)
                pos_reg <= rcfp_pkg::IDX_FIRST;
            else
                pos_reg <= pos_reg + IDX_W'(1);
            if (pos_reg == rcfp_pkg::IDX_HDR1)
                xor_reg <= 8'd0;
            else if (pos_reg < rcfp_pkg::IDX_CSUM)
                xor_reg <= xor_reg ^ m_axis_tdata;
        end
    end

    a_hdr0: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && pos_reg == rcfp_pkg::IDX_FIRST) |->
            (m_axis_tdata == rcfp_pkg::HDR_BYTE0))
        else $error("frame does not open with first header byte");

    a_hdr1: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && pos_reg == rcfp_pkg::IDX_HDR1) |->
            (m_axis_tdata == rcfp_pkg::HDR_BYTE1))
        else $error("second header byte wrong");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (pos_reg == rcfp_pkg::IDX_LAST)))
        else $error("tlast not on the tenth byte");

    a_csum: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && pos_reg == rcfp_pkg::IDX_CSUM) |-> (m_axis_tdata == xor_reg))
        else $error("checksum byte mismatch");

    a_inv: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && pos_reg == rcfp_pkg::IDX_LAST) |->
            (m_axis_tdata == (prev_reg ^ rcfp_pkg::CSUM_INV)))
        else $error("inverted checksum byte mismatch");

endmodule

bind robot_command_frame_packer_unit rcfp_checker u_rcfp_checker (.*);

`default_nettype wire
